@@ rtl/h2rgb_pkg.sv @@
package h2rgb_pkg;

  // Fixed-point scales of the color formats.
  localparam int unsigned HUE_TURN   = 23040;  // 360 degrees in 1/64 degree
  localparam int unsigned HUE_SECTOR = 3840;   // 60 degrees in 1/64 degree
  localparam int unsigned UNIT_ONE   = 256;    // 1.0 for saturation and value

  // Input and output field widths.
  localparam int unsigned HUE_W  = 16;
  localparam int unsigned FRAC_W = 9;
  localparam int unsigned CHAN_W = 8;

  // Internal widths: reduced hue, chroma/offset with 16 fraction bits,
  // in-sector position, and channel sums scaled by 65536*3840.
  localparam int unsigned HRED_W = 15;
  localparam int unsigned CM_W   = 17;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned SUM_W  = 28;
  localparam int unsigned SCL_W  = 32;

  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [CHAN_W-1:0] chan_t;

  // 60-degree sectors of the hue circle.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

endpackage

@@ rtl/hsv_to_rgb_converter.sv @@
// HSV to RGB color converter.
// Input channel: in_hue (1/64 degree, any value, reduced modulo 360 degrees),
// in_saturation and in_brightness (8 fraction bits, 256 = 1.0). A transfer
// takes place at a rising edge where start is high and busy is low; busy is
// always low, so a new color can be started in every cycle.
// Result channel: out_red, out_green, out_blue and out_out_of_range are shown
// for exactly one cycle, marked by out_valid, and the transfer completes at
// the edge that ends that cycle. The receiver cannot stall the block.
// Pipeline: five register stages lie between an input transfer and its
// result (hue reduction and chroma product, sector split, channel products,
// channel sums, scaling by 255 and output register).
// Throughput: one color per clock, fixed by the fully pipelined datapath.
// Saturation or brightness above 1.0 gives a black result with
// out_out_of_range set.
// Reset (rst_n low, synchronous) clears all stage valid bits, so no result
// is shown until new inputs have passed through the pipeline.
module hsv_to_rgb_converter (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  h2rgb_pkg::hue_t           in_hue,
  input  h2rgb_pkg::frac_t          in_saturation,
  input  h2rgb_pkg::frac_t          in_brightness,
  output logic                      out_valid,
  output h2rgb_pkg::chan_t          out_red,
  output h2rgb_pkg::chan_t          out_green,
  output h2rgb_pkg::chan_t          out_blue,
  output logic                      out_out_of_range
);

  localparam int unsigned HRED_W = h2rgb_pkg::HRED_W;
  localparam int unsigned CM_W   = h2rgb_pkg::CM_W;
  localparam int unsigned POS_W  = h2rgb_pkg::POS_W;
  localparam int unsigned SUM_W  = h2rgb_pkg::SUM_W;
  localparam int unsigned SCL_W  = h2rgb_pkg::SCL_W;
  localparam int unsigned HUE_W  = h2rgb_pkg::HUE_W;
  localparam int unsigned FRAC_W = h2rgb_pkg::FRAC_W;
  localparam int unsigned CHAN_W = h2rgb_pkg::CHAN_W;

  localparam logic [HUE_W-1:0]  TURN1 = HUE_W'(h2rgb_pkg::HUE_TURN);
  localparam logic [HUE_W-1:0]  TURN2 = HUE_W'(2 * h2rgb_pkg::HUE_TURN);
  localparam logic [FRAC_W-1:0] ONE   = FRAC_W'(h2rgb_pkg::UNIT_ONE);
  localparam logic [HRED_W-1:0] B1    = HRED_W'(1 * h2rgb_pkg::HUE_SECTOR);
  localparam logic [HRED_W-1:0] B2    = HRED_W'(2 * h2rgb_pkg::HUE_SECTOR);
  localparam logic [HRED_W-1:0] B3    = HRED_W'(3 * h2rgb_pkg::HUE_SECTOR);
  localparam logic [HRED_W-1:0] B4    = HRED_W'(4 * h2rgb_pkg::HUE_SECTOR);
  localparam logic [HRED_W-1:0] B5    = HRED_W'(5 * h2rgb_pkg::HUE_SECTOR);
  localparam logic [POS_W-1:0]  SPAN  = POS_W'(h2rgb_pkg::HUE_SECTOR);

  // The datapath never stalls.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------- stage 1
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_oor_r, s1_oor_nxt;
  logic [HRED_W-1:0]   s1_h_r, s1_h_nxt;
  logic [CM_W-1:0]     s1_c_r, s1_c_nxt;
  logic [FRAC_W-1:0]   s1_v_r;
  logic [HUE_W-1:0]    hue_diff;
  logic [2*FRAC_W-1:0] sv_prod;

  // Reduce the hue modulo one turn and form the chroma product.
  always_comb begin
    if (in_hue >= TURN2) begin
      hue_diff = in_hue - TURN2;
    end else if (in_hue >= TURN1) begin
      hue_diff = in_hue - TURN1;
    end else begin
      hue_diff = in_hue;
    end
    s1_h_nxt     = hue_diff[HRED_W-1:0];
    sv_prod      = in_saturation * in_brightness;
    s1_c_nxt     = sv_prod[CM_W-1:0];
    s1_oor_nxt   = (in_saturation > ONE) || (in_brightness > ONE);
    s1_valid_nxt = accept;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
    s1_oor_r <= s1_oor_nxt;
    s1_h_r   <= s1_h_nxt;
    s1_c_r   <= s1_c_nxt;
    s1_v_r   <= in_brightness;
  end

  // ---------------------------------------------------------------- stage 2
  logic                 s2_valid_r, s2_oor_r;
  h2rgb_pkg::sector_t   s2_sector_r, s2_sector_nxt;
  logic [POS_W-1:0]     s2_k_r, s2_k_nxt;
  logic [CM_W-1:0]      s2_c_r;
  logic [CM_W-1:0]      s2_m_r, s2_m_nxt;
  logic [HRED_W-1:0]    base;
  logic                 odd;
  logic [HRED_W-1:0]    pos;

  // Split the hue into a sector and a ramp position; the ramp falls in
  // odd sectors. Also form the offset m = v - c.
  always_comb begin
    if (s1_h_r >= B5) begin
      s2_sector_nxt = h2rgb_pkg::SEC_MAG_RED; base = B5; odd = 1'b1;
    end else if (s1_h_r >= B4) begin
      s2_sector_nxt = h2rgb_pkg::SEC_BLU_MAG; base = B4; odd = 1'b0;
    end else if (s1_h_r >= B3) begin
      s2_sector_nxt = h2rgb_pkg::SEC_CYN_BLU; base = B3; odd = 1'b1;
    end else if (s1_h_r >= B2) begin
      s2_sector_nxt = h2rgb_pkg::SEC_GRN_CYN; base = B2; odd = 1'b0;
    end else if (s1_h_r >= B1) begin
      s2_sector_nxt = h2rgb_pkg::SEC_YEL_GRN; base = B1; odd = 1'b1;
    end else begin
      s2_sector_nxt = h2rgb_pkg::SEC_RED_YEL; base = '0; odd = 1'b0;
    end
    pos      = s1_h_r - base;
    s2_k_nxt = odd ? (SPAN - pos[POS_W-1:0]) : pos[POS_W-1:0];
    s2_m_nxt = {s1_v_r, 8'd0} - s1_c_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_oor_r    <= s1_oor_r;
    s2_sector_r <= s2_sector_nxt;
    s2_k_r      <= s2_k_nxt;
    s2_c_r      <= s1_c_r;
    s2_m_r      <= s2_m_nxt;
  end

  // ---------------------------------------------------------------- stage 3
  logic                s3_valid_r, s3_oor_r;
  h2rgb_pkg::sector_t  s3_sector_r;
  logic [SUM_W-1:0]    s3_ck_r, s3_cs_r, s3_ms_r;

  // Channel products, all scaled by 65536*3840: c*k, c*3840 and m*3840.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_oor_r    <= s2_oor_r;
    s3_sector_r <= s2_sector_r;
    s3_ck_r     <= SUM_W'(s2_c_r) * SUM_W'(s2_k_r);
    s3_cs_r     <= SUM_W'(s2_c_r) * SUM_W'(SPAN);
    s3_ms_r     <= SUM_W'(s2_m_r) * SUM_W'(SPAN);
  end

  // ---------------------------------------------------------------- stage 4
  logic             s4_valid_r, s4_oor_r;
  logic [SUM_W-1:0] s4_r_r, s4_g_r, s4_b_r;
  logic [SUM_W-1:0] s4_r_nxt, s4_g_nxt, s4_b_nxt;
  logic [SUM_W-1:0] r_term, g_term, b_term;

  // Route chroma and ramp to the channels by sector, then add the offset.
  always_comb begin
    case (s3_sector_r)
      h2rgb_pkg::SEC_RED_YEL: begin
        r_term = s3_cs_r; g_term = s3_ck_r; b_term = '0;
      end
      h2rgb_pkg::SEC_YEL_GRN: begin
        r_term = s3_ck_r; g_term = s3_cs_r; b_term = '0;
      end
      h2rgb_pkg::SEC_GRN_CYN: begin
        r_term = '0; g_term = s3_cs_r; b_term = s3_ck_r;
      end
      h2rgb_pkg::SEC_CYN_BLU: begin
        r_term = '0; g_term = s3_ck_r; b_term = s3_cs_r;
      end
      h2rgb_pkg::SEC_BLU_MAG: begin
        r_term = s3_ck_r; g_term = '0; b_term = s3_cs_r;
      end
      default: begin
        r_term = s3_cs_r; g_term = '0; b_term = s3_ck_r;
      end
    endcase
    s4_r_nxt = r_term + s3_ms_r;
    s4_g_nxt = g_term + s3_ms_r;
    s4_b_nxt = b_term + s3_ms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= s3_valid_r;
    end
    s4_oor_r <= s3_oor_r;
    s4_r_r   <= s4_r_nxt;
    s4_g_r   <= s4_g_nxt;
    s4_b_r   <= s4_b_nxt;
  end

  // ---------------------------------------------------------------- output
  // 255 / (65536*3840) equals 17 / 2^24, so each channel is the top byte
  // of 17 times its sum. Out-of-range colors are forced to black.
  logic [SCL_W-1:0]  r_scl, g_scl, b_scl;
  logic              out_valid_r;
  logic              out_oor_r;
  logic [CHAN_W-1:0] out_red_r, out_green_r, out_blue_r;
  logic [CHAN_W-1:0] out_red_nxt, out_green_nxt, out_blue_nxt;

  always_comb begin
    r_scl = {s4_r_r, 4'd0} + SCL_W'(s4_r_r);
    g_scl = {s4_g_r, 4'd0} + SCL_W'(s4_g_r);
    b_scl = {s4_b_r, 4'd0} + SCL_W'(s4_b_r);
    if (s4_oor_r) begin
      out_red_nxt   = '0;
      out_green_nxt = '0;
      out_blue_nxt  = '0;
    end else begin
      out_red_nxt   = r_scl[SCL_W-1 -: CHAN_W];
      out_green_nxt = g_scl[SCL_W-1 -: CHAN_W];
      out_blue_nxt  = b_scl[SCL_W-1 -: CHAN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
    out_oor_r   <= s4_oor_r;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_red          = out_red_r;
  assign out_green        = out_green_r;
  assign out_blue         = out_blue_r;
  assign out_out_of_range = out_oor_r;

endmodule

@@ rtl/h2rgb_checker.sv @@
module h2rgb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input h2rgb_pkg::hue_t           in_hue,
  input h2rgb_pkg::frac_t          in_saturation,
  input h2rgb_pkg::frac_t          in_brightness,
  input logic                      out_valid,
  input h2rgb_pkg::chan_t          out_red,
  input h2rgb_pkg::chan_t          out_green,
  input h2rgb_pkg::chan_t          out_blue,
  input logic                      out_out_of_range
);

  localparam int unsigned FRAC_W = h2rgb_pkg::FRAC_W;
  localparam logic [FRAC_W-1:0] ONE = FRAC_W'(h2rgb_pkg::UNIT_ONE);

  logic in_xfer;
  assign in_xfer = start && !busy && rst_n;

  // Every input transfer produces a result strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |-> ##5 out_valid)
    else $error("result strobe missing after input transfer");

  // An out-of-range result is black.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("out-of-range result is not black");

  // Saturation or brightness above 1.0 raises the flag on its result.
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && (in_saturation > ONE || in_brightness > ONE)) |->
      ##5 out_out_of_range)
    else $error("out-of-range flag missing");

  // Full saturation and brightness drive the leading channel to 255.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_saturation == ONE && in_brightness == ONE) |->
      ##5 (!out_out_of_range &&
           (out_red == 8'd255 || out_green == 8'd255 || out_blue == 8'd255)))
    else $error("fully saturated color lacks a full channel");

endmodule

bind hsv_to_rgb_converter h2rgb_checker u_h2rgb_checker (.*);
